>>> rtl/core/fsr_pkg.sv
// fsr_pkg: shared types and constants of the queue core with search, sort and reverse
// used by the channel interfaces, the compare unit and the top level
package fsr_pkg;

	localparam int DEPTH  = 16;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int FUNC_W = 3;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	typedef logic [FUNC_W-1:0]        func_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [STAT_W-1:0]        stat_t;
	typedef logic [OCC_W-1:0]         occ_t;

	localparam func_t OP_ENQ  = 3'd0;
	localparam func_t OP_DEQ  = 3'd1;
	localparam func_t OP_SRCH = 3'd2;
	localparam func_t OP_SORT = 3'd3;
	localparam func_t OP_REV  = 3'd4;

	localparam stat_t ST_OK    = 2'd0;
	localparam stat_t ST_EMPTY = 2'd1;
	localparam stat_t ST_FULL  = 2'd2;

	typedef struct packed {
		logic eq;
		logic gt;
	} cmp_res_t;

endpackage

>>> rtl/core/fsr_req_if.sv
// fsr_req_if: request channel, one word carries an operation and a value
// depends on fsr_pkg
interface fsr_req_if;
	logic           valid;
	logic           ready;
	fsr_pkg::func_t func;
	fsr_pkg::data_t value;

	modport source(output valid, func, value, input ready);
	modport sink(input valid, func, value, output ready);
endinterface

>>> rtl/core/fsr_rsp_if.sv
// fsr_rsp_if: response channel, one word carries status, found bit and occupancy
// depends on fsr_pkg
interface fsr_rsp_if;
	logic           valid;
	logic           ready;
	fsr_pkg::stat_t status;
	logic           found;
	fsr_pkg::occ_t  occupancy;

	modport source(output valid, status, found, occupancy, input ready);
	modport sink(input valid, status, found, occupancy, output ready);
endinterface

>>> rtl/core/fifo_with_search_sort_reverse_core.sv
// fifo_with_search_sort_reverse_core: bounded queue of signed words with search, sort, reverse
// depends on fsr_pkg, fsr_req_if, fsr_rsp_if, fsr_cmp
//
//   port  dir   contents                        handshake
//   req   in    func, value                     valid/ready
//   rsp   out   status, found, occupancy        valid/ready
//
// enqueue, dequeue and unused codes go straight to the response; search compares
// every held word, reverse swaps pairs from the ends inward; sort runs bubble passes,
// up to n-1 passes for n held words, all on one memory port and one compare unit
// req is ready only while the sequencer is idle; a stalled rsp word holds in its
// register and the next req word is still taken
// arst_n empties the queue; the store itself is not cleared
module fifo_with_search_sort_reverse_core (
	input logic       clk,
	input logic       arst_n,
	fsr_req_if.sink   req,
	fsr_rsp_if.source rsp
);
	import fsr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_SORT_LD,
		S_SORT_CUR,
		S_SORT_RD,
		S_SORT_CMP,
		S_SORT_END,
		S_REV_RDA,
		S_REV_RDB,
		S_REV_WA,
		S_REV_WB,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [PTR_W-1:0]   head_q;
	logic [CNT_W-1:0]   fill_q;
	logic [PTR_W-1:0]   idx_q;
	logic [PTR_W-1:0]   last_q;
	logic               swapped_q;
	data_t              cur_q;
	data_t              value_q;
	stat_t              status_q;
	logic               found_q;
	logic               rsp_valid_q;
	stat_t              rsp_status_q;
	logic               rsp_found_q;
	occ_t               rsp_occ_q;

	data_t              mem_q [DEPTH];
	data_t              rd_q;
	logic [PTR_W-1:0]   raddr;
	logic [PTR_W-1:0]   waddr;
	data_t              wdata;
	logic               we;
	logic               accept;
	logic               full;
	logic               empty;
	data_t              cmp_a;
	cmp_res_t           cmp;

	function automatic logic [PTR_W-1:0] slot(input logic [PTR_W-1:0] head,
			input logic [PTR_W-1:0] pos);
		logic [PTR_W:0] sum;
		sum = {1'b0, head} + {1'b0, pos};
		if (sum >= (PTR_W+1)'(DEPTH)) begin
			sum = sum - (PTR_W+1)'(DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (fill_q == CNT_W'(DEPTH));
	assign empty     = (fill_q == '0);

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.found     = rsp_found_q;
	assign rsp.occupancy = rsp_occ_q;

	assign cmp_a = (state_q == S_SRCH_CMP) ? value_q : cur_q;

	fsr_cmp u_cmp (
		.a  (cmp_a),
		.b  (rd_q),
		.res(cmp)
	);

	always_comb begin
		raddr = (state_q == S_REV_RDB) ? slot(head_q, last_q) : slot(head_q, idx_q);
		we    = 1'b0;
		waddr = slot(head_q, idx_q);
		wdata = cur_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req.func == OP_ENQ && !full) begin
					we    = 1'b1;
					waddr = slot(head_q, fill_q[PTR_W-1:0]);
					wdata = req.value;
				end
			end
			S_SORT_CMP: begin
				we    = 1'b1;
				waddr = slot(head_q, idx_q - PTR_W'(1));
				wdata = cmp.gt ? rd_q : cur_q;
			end
			S_SORT_END: begin
				we    = 1'b1;
				waddr = slot(head_q, last_q);
				wdata = cur_q;
			end
			S_REV_WA: begin
				we    = 1'b1;
				waddr = slot(head_q, idx_q);
				wdata = rd_q;
			end
			S_REV_WB: begin
				we    = 1'b1;
				waddr = slot(head_q, last_q);
				wdata = cur_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// word store, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			last_q      <= '0;
			swapped_q   <= 1'b0;
			status_q    <= ST_OK;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						value_q  <= req.value;
						status_q <= ST_OK;
						found_q  <= 1'b0;
						idx_q    <= '0;
						last_q   <= PTR_W'(fill_q - CNT_W'(1));
						swapped_q <= 1'b0;
						state_q  <= S_DONE;
						case (req.func)
							OP_ENQ: begin
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									fill_q <= fill_q + CNT_W'(1);
								end
							end
							OP_DEQ: begin
								if (empty) begin
									status_q <= ST_EMPTY;
								end else begin
									fill_q <= fill_q - CNT_W'(1);
									head_q <= (fill_q == CNT_W'(1)) ? '0
										: slot(head_q, PTR_W'(1));
								end
							end
							OP_SRCH: begin
								if (!empty) begin
									state_q <= S_SRCH_RD;
								end
							end
							OP_SORT: begin
								if (fill_q > CNT_W'(1)) begin
									state_q <= S_SORT_LD;
								end
							end
							OP_REV: begin
								if (fill_q > CNT_W'(1)) begin
									state_q <= S_REV_RDA;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SRCH_RD: begin
					state_q <= S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					if (cmp.eq) begin
						found_q <= 1'b1;
					end
					if (idx_q == PTR_W'(fill_q - CNT_W'(1))) begin
						state_q <= S_DONE;
					end else begin
						idx_q   <= idx_q + PTR_W'(1);
						state_q <= S_SRCH_RD;
					end
				end
				S_SORT_LD: begin
					state_q <= S_SORT_CUR;
				end
				S_SORT_CUR: begin
					cur_q   <= rd_q;
					idx_q   <= PTR_W'(1);
					state_q <= S_SORT_RD;
				end
				S_SORT_RD: begin
					state_q <= S_SORT_CMP;
				end
				// larger word bubbles toward the tail
				S_SORT_CMP: begin
					if (cmp.gt) begin
						swapped_q <= 1'b1;
					end else begin
						cur_q <= rd_q;
					end
					if (idx_q == last_q) begin
						state_q <= S_SORT_END;
					end else begin
						idx_q   <= idx_q + PTR_W'(1);
						state_q <= S_SORT_RD;
					end
				end
				S_SORT_END: begin
					if (swapped_q && last_q > PTR_W'(1)) begin
						last_q    <= last_q - PTR_W'(1);
						idx_q     <= '0;
						swapped_q <= 1'b0;
						state_q   <= S_SORT_LD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_REV_RDA: begin
					state_q <= S_REV_RDB;
				end
				S_REV_RDB: begin
					cur_q   <= rd_q;
					state_q <= S_REV_WA;
				end
				S_REV_WA: begin
					state_q <= S_REV_WB;
				end
				S_REV_WB: begin
					if (({1'b0, idx_q} + (PTR_W+1)'(2)) < {1'b0, last_q}) begin
						idx_q   <= idx_q + PTR_W'(1);
						last_q  <= last_q - PTR_W'(1);
						state_q <= S_REV_RDA;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_q;
						rsp_found_q  <= found_q;
						rsp_occ_q    <= OCC_W'(fill_q);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == '0 |-> head_q == '0)
		else $error("head not at zero on empty queue");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> rsp.occupancy == OCC_W'(DEPTH))
		else $error("full status with room left");

	a_empty_deq: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_EMPTY |-> rsp.occupancy == '0 && !rsp.found)
		else $error("empty status on held words");

endmodule

>>> rtl/core/fsr_cmp.sv
// fsr_cmp: shared signed compare unit for search and sort
// depends on fsr_pkg
module fsr_cmp (
	input  fsr_pkg::data_t   a,
	input  fsr_pkg::data_t   b,
	output fsr_pkg::cmp_res_t res
);
	import fsr_pkg::*;

	always_comb begin
		res.eq = (a == b);
		res.gt = (a > b);
	end
endmodule
